// ===== src/dht_pkg.sv =====
// Shared types, codes and constants for the single-wire humidity sensor decoder.
package dht_pkg;

   localparam int CMD_W    = 2;
   localparam int STAMP_W  = 16;
   localparam int TICK_W   = 8;
   localparam int THR_W    = 16;
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int FRAME_W  = 40;
   localparam int BITCNT_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_EDGES_DEF  = 128;
   localparam int FIRST_BIT_EDGE = 3;

   // Input commands
   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_TICKS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_THR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_THR      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_END_THR      = 3'd4;

   // Register reset values
   localparam logic [TICK_W-1:0] START_TICKS_RST  = 8'd18;
   localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 8'd10;
   localparam logic [THR_W-1:0]  ZERO_THR_RST     = 16'd40;
   localparam logic [THR_W-1:0]  ONE_THR_RST      = 16'd60;
   localparam logic [THR_W-1:0]  END_THR_RST      = 16'd200;

   typedef struct packed {
      logic [TICK_W-1:0] start_ticks;
      logic [TICK_W-1:0] window_ticks;
      logic [THR_W-1:0]  zero_threshold;
      logic [THR_W-1:0]  one_threshold;
      logic [THR_W-1:0]  end_threshold;
   } cfg_type;

   typedef struct packed {
      logic              drive_low;
      logic              capturing;
      logic              acq_done;
      logic              checksum_bad;
      logic              start_refused;
      logic [WORD_W-1:0] humidity_word;
      logic [WORD_W-1:0] temperature_word;
      logic [BYTE_W-1:0] check_byte;
   } rsp_type;

endpackage

// ===== src/dht_if.sv =====
// Channel interfaces: request, response and register write.
interface dht_req_if;
   import dht_pkg::*;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [STAMP_W-1:0] timestamp;
   modport source (output valid, cmd, timestamp, input ready);
   modport sink   (input valid, cmd, timestamp, output ready);
endinterface

interface dht_rsp_if;
   import dht_pkg::*;
   logic              valid;
   logic              ready;
   logic              drive_low;
   logic              capturing;
   logic              acq_done;
   logic              checksum_bad;
   logic              start_refused;
   logic [WORD_W-1:0] humidity_word;
   logic [WORD_W-1:0] temperature_word;
   logic [BYTE_W-1:0] check_byte;
   modport source (output valid, drive_low, capturing, acq_done, checksum_bad, start_refused,
                   humidity_word, temperature_word, check_byte, input ready);
   modport sink   (input valid, drive_low, capturing, acq_done, checksum_bad, start_refused,
                   humidity_word, temperature_word, check_byte, output ready);
endinterface

interface dht_csr_if;
   import dht_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/dht_cfg_regs.sv =====
// Configuration register file for the decoder.
module dht_cfg_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [dht_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [dht_pkg::CSR_DATA_W-1:0] wr_data,
   output dht_pkg::cfg_type               cfg
);
   import dht_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_ticks    <= START_TICKS_RST;
         cfg_ff.window_ticks   <= WINDOW_TICKS_RST;
         cfg_ff.zero_threshold <= ZERO_THR_RST;
         cfg_ff.one_threshold  <= ONE_THR_RST;
         cfg_ff.end_threshold  <= END_THR_RST;
      end else if (wr_en) begin
         unique case (wr_index)
            REG_START_TICKS:  cfg_ff.start_ticks    <= wr_data[TICK_W-1:0];
            REG_WINDOW_TICKS: cfg_ff.window_ticks   <= wr_data[TICK_W-1:0];
            REG_ZERO_THR:     cfg_ff.zero_threshold <= wr_data[THR_W-1:0];
            REG_ONE_THR:      cfg_ff.one_threshold  <= wr_data[THR_W-1:0];
            REG_END_THR:      cfg_ff.end_threshold  <= wr_data[THR_W-1:0];
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/dht_core.sv =====
// Acquisition state, bit decode and result register.
module dht_core #(
   parameter int MAX_EDGES = dht_pkg::MAX_EDGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [dht_pkg::CMD_W-1:0]   cmd,
   input  logic [dht_pkg::STAMP_W-1:0] timestamp,
   input  dht_pkg::cfg_type            cfg,
   output dht_pkg::rsp_type            rsp
);
   import dht_pkg::*;

   localparam int EdgeW = $clog2(MAX_EDGES + 1);

   typedef enum logic [1:0] {PH_IDLE, PH_START, PH_CAPTURE, PH_END} phase_type;

   phase_type            phase_ff, phase_in;
   logic [TICK_W-1:0]    tick_count_ff, tick_count_in, tick_dec;
   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [EdgeW-1:0]     edge_index_ff, edge_index_in;
   logic [STAMP_W-1:0]   last_stamp_ff, last_stamp_in;
   logic                 frame_ended_ff, frame_ended_in;
   logic [BITCNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [FRAME_W-1:0]   frame_bits_ff, frame_bits_in;
   logic                 bad, refused;
   logic [STAMP_W-1:0]   diff;
   logic [BYTE_W-1:0]    sum;
   rsp_type              rsp_ff, rsp_in;

   assign tick_dec = (tick_count_ff != '0) ? tick_count_ff - TICK_W'(1) : tick_count_ff;
   assign diff     = timestamp - last_stamp_ff;
   assign sum      = frame_bits_ff[39:32] + frame_bits_ff[31:24]
                   + frame_bits_ff[23:16] + frame_bits_ff[15:8];

   always_comb begin
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      running_in     = running_ff;
      done_in        = done_ff;
      edge_index_in  = edge_index_ff;
      last_stamp_in  = last_stamp_ff;
      frame_ended_in = frame_ended_ff;
      bit_count_in   = bit_count_ff;
      frame_bits_in  = frame_bits_ff;
      bad            = 1'b0;
      refused        = 1'b0;

      case (cmd)
         CMD_START: begin
            if (running_ff) begin
               refused = 1'b1;
            end else begin
               running_in = 1'b1;
               done_in    = 1'b0;
               phase_in   = PH_IDLE;
            end
         end
         CMD_TICK: begin
            tick_count_in = tick_dec;
            unique case (phase_ff)
               PH_IDLE: begin
                  if (running_ff) begin
                     phase_in      = PH_START;
                     tick_count_in = cfg.start_ticks;
                  end
               end
               PH_START: begin
                  if (tick_dec == '0) begin
                     phase_in       = PH_CAPTURE;
                     tick_count_in  = cfg.window_ticks;
                     edge_index_in  = '0;
                     last_stamp_in  = '0;
                     frame_ended_in = 1'b0;
                     bit_count_in   = '0;
                     frame_bits_in  = '0;
                  end
               end
               PH_CAPTURE: begin
                  if (tick_dec == '0) phase_in = PH_END;
               end
               PH_END: begin
                  phase_in = PH_IDLE;
                  if (sum == frame_bits_ff[7:0]) begin
                     running_in = 1'b0;
                     done_in    = 1'b1;
                  end else begin
                     bad = 1'b1;  // running stays set: retry from idle
                  end
               end
               default: ;
            endcase
         end
         CMD_EDGE: begin
            if (phase_ff == PH_CAPTURE && edge_index_ff < EdgeW'(MAX_EDGES)) begin
               if (edge_index_ff >= EdgeW'(FIRST_BIT_EDGE) && !frame_ended_ff) begin
                  if (diff > cfg.end_threshold) begin
                     frame_ended_in = 1'b1;
                  end else if (diff < cfg.zero_threshold || diff > cfg.one_threshold) begin
                     if (bit_count_ff < BITCNT_W'(FRAME_W)) begin
                        if (diff > cfg.one_threshold)
                           frame_bits_in[BITCNT_W'(FRAME_W - 1) - bit_count_ff] = 1'b1;
                        bit_count_in = bit_count_ff + BITCNT_W'(1);
                     end
                  end
               end
               last_stamp_in = timestamp;
               edge_index_in = edge_index_ff + EdgeW'(1);
            end
         end
         default: ;  // unused command
      endcase

      rsp_in.drive_low        = (phase_in == PH_START);
      rsp_in.capturing        = (phase_in == PH_CAPTURE);
      rsp_in.acq_done         = done_in;
      rsp_in.checksum_bad     = bad;
      rsp_in.start_refused    = refused;
      rsp_in.humidity_word    = frame_bits_in[39:24];
      rsp_in.temperature_word = frame_bits_in[23:8];
      rsp_in.check_byte       = frame_bits_in[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tick_count_ff  <= '0;
         running_ff     <= 1'b0;
         done_ff        <= 1'b0;
         edge_index_ff  <= '0;
         last_stamp_ff  <= '0;
         frame_ended_ff <= 1'b0;
         bit_count_ff   <= '0;
         frame_bits_ff  <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         running_ff     <= running_in;
         done_ff        <= done_in;
         edge_index_ff  <= edge_index_in;
         last_stamp_ff  <= last_stamp_in;
         frame_ended_ff <= frame_ended_in;
         bit_count_ff   <= bit_count_in;
         frame_bits_ff  <= frame_bits_in;
      end
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

// ===== src/dht_sensor_acquire_decode.sv =====
// Top level of the single-wire humidity/temperature sensor acquisition and decode block.
//
// Use:
//  - req_bus carries one command per beat: start request, timer tick, or a
//    captured edge with its 16-bit timer stamp. Ticks walk the acquisition
//    through start pulse, capture window and end; edges in the window are
//    decoded into a 40-bit frame, checked on the end tick.
//  - rsp_bus returns exactly one beat per request beat, showing the state
//    after that command: line-drive and window flags, the done flag, checksum-bad /
//    refused pulses and the current frame words.
//  - csr_bus writes the five timing and threshold registers; always ready.
//    Write only while no request is in flight.
// Timing:
//  - A request beat is held in the input register, then decoded against the
//    state into the result register in one compare-and-shift step.
//  - Throughput one beat per cycle while rsp_bus is ready.
// Reset: synchronous; registers return to their defaults, state to idle,
//  frame cleared, no result pending.
// Stall: while rsp_bus is held off the result register keeps its beat and
//  one more request still enters the input register; then req_bus.ready drops.
module dht_sensor_acquire_decode #(
   parameter int MAX_EDGES = dht_pkg::MAX_EDGES_DEF
) (
   input logic      clock,
   input logic      reset,
   dht_req_if.sink   req_bus,
   dht_rsp_if.source rsp_bus,
   dht_csr_if.sink   csr_bus
);
   import dht_pkg::*;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]   in_cmd_ff;
   logic [STAMP_W-1:0] in_stamp_ff;
   // result register valid
   logic               out_valid_ff, out_valid_in;
   logic               advance;
   logic               req_take;
   cfg_type            cfg;
   rsp_type            rsp;

   // Decode moves a beat on when the result register is free or being emptied.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         in_cmd_ff   <= req_bus.cmd;
         in_stamp_ff <= req_bus.timestamp;
      end
   end

   assign csr_bus.ready = 1'b1;

   dht_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   dht_core #(.MAX_EDGES(MAX_EDGES)) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cmd       (in_cmd_ff),
      .timestamp (in_stamp_ff),
      .cfg       (cfg),
      .rsp       (rsp)
   );

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.drive_low        = rsp.drive_low;
   assign rsp_bus.capturing        = rsp.capturing;
   assign rsp_bus.acq_done         = rsp.acq_done;
   assign rsp_bus.checksum_bad     = rsp.checksum_bad;
   assign rsp_bus.start_refused    = rsp.start_refused;
   assign rsp_bus.humidity_word    = rsp.humidity_word;
   assign rsp_bus.temperature_word = rsp.temperature_word;
   assign rsp_bus.check_byte       = rsp.check_byte;

   // Start pulse and capture window are exclusive phases.
   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(rsp.drive_low && rsp.capturing))
      else $error("drive_low and capturing both set");

   // A held reading always carries a matching checksum.
   a_done_sum: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp.acq_done) |->
         (BYTE_W'(rsp.humidity_word[15:8] + rsp.humidity_word[7:0]
                 + rsp.temperature_word[15:8] + rsp.temperature_word[7:0])
          == rsp.check_byte))
      else $error("acq_done with bad checksum");

   // Refusal and checksum failure come from different commands.
   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(rsp.checksum_bad && rsp.start_refused))
      else $error("checksum_bad and start_refused together");

   // An empty result register never blocks the request side.
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_bus.ready)
      else $error("request stalled with empty result register");

endmodule
